/* hdl/stepper_calibrate_and_index_macros.svh */
// Assertion macros used by the stepper sequencer RTL (sci_ctrl).
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef STEPPER_CALIBRATE_AND_INDEX_MACROS_SVH
`define STEPPER_CALIBRATE_AND_INDEX_MACROS_SVH

// Check a property on every clock while out of reset
`define SCI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the following clock
`define SCI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sci_pkg.sv */
// Shared types, constants and the half-step table for the stepper controller.
// No dependencies; imported by every module of the block.
package sci_pkg;

	localparam int PARTS_DEF       = 8;
	localparam int CAL_ROUNDS_DEF  = 3;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int OFFSET_W         = 10;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd155;
	localparam int PARTS_LEFT_W     = 8;
	localparam int REV_OUT_W        = 16;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_CAL    = 2'd1,
		CMD_STATUS = 2'd2,
		CMD_RUN    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_ACCEPT  = 2'd1,
		ST_NOCAL   = 2'd2,
		ST_BUSY    = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		M_IDLE  = 8'b0000_0001,
		M_SEEK1 = 8'b0000_0010,
		M_BACK  = 8'b0000_0100,
		M_SEEK2 = 8'b0000_1000,
		M_LOW   = 8'b0001_0000,
		M_HIGH  = 8'b0010_0000,
		M_FINAL = 8'b0100_0000,
		M_RUN   = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		cmd_t              cmd;
		logic signed [7:0] run_parts;
		logic              sensor_level;
	} req_item_t;

	typedef struct packed {
		logic [3:0]           coil_pattern;
		logic                 busy_res;
		logic                 calibrated;
		logic [REV_OUT_W-1:0] revolution_steps;
		status_t              status_code;
	} rsp_item_t;

	// Control from the sequencer to the averaging counters
	typedef struct packed {
		logic clear;
		logic inc;
	} avg_ctl_t;

	// Half-step coil patterns, bit 0 is coil 1
	function automatic logic [3:0] phase_pattern(input logic [2:0] idx);
		logic [3:0] pat;
		case (idx)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			3'd7: pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

/* hdl/sci_avg.sv */
// Running quotient counters: total counted steps / CAL_ROUNDS, and that / PARTS.
// Depends on sci_pkg. Replaces the divide by counting one step at a time.
module sci_avg import sci_pkg::*; #(
	parameter int PARTS       = PARTS_DEF,
	parameter int CAL_ROUNDS  = CAL_ROUNDS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  avg_ctl_t                                 ctl,
	output logic [COUNT_WIDTH-1:0]                   quot,
	output logic [COUNT_WIDTH-1:0]                   seg_base,
	output logic [((PARTS > 1) ? $clog2(PARTS) : 1)-1:0] seg_rem
);
	localparam int PW = (PARTS > 1) ? $clog2(PARTS) : 1;
	localparam int AW = (CAL_ROUNDS > 1) ? $clog2(CAL_ROUNDS) : 1;
	localparam logic [AW-1:0] LAST_ROUND_REM = AW'(CAL_ROUNDS - 1);
	localparam logic [PW-1:0] LAST_PART      = PW'(PARTS - 1);

	logic [AW-1:0]          rnd_rem_q;
	logic [COUNT_WIDTH-1:0] quot_q;
	logic [COUNT_WIDTH-1:0] base_q;
	logic [PW-1:0]          part_rem_q;

	// Clear at calibration start, advance one counted step at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_rem_q  <= '0;
			quot_q     <= '0;
			base_q     <= '0;
			part_rem_q <= '0;
		end else if (ctl.clear) begin
			rnd_rem_q  <= '0;
			quot_q     <= '0;
			base_q     <= '0;
			part_rem_q <= '0;
		end else if (ctl.inc) begin
			if (rnd_rem_q == LAST_ROUND_REM) begin
				rnd_rem_q <= '0;
				quot_q    <= quot_q + 1'b1;
				if (part_rem_q == LAST_PART) begin
					part_rem_q <= '0;
					base_q     <= base_q + 1'b1;
				end else begin
					part_rem_q <= part_rem_q + 1'b1;
				end
			end else begin
				rnd_rem_q <= rnd_rem_q + 1'b1;
			end
		end
	end

	assign quot     = quot_q;
	assign seg_base = base_q;
	assign seg_rem  = part_rem_q;

endmodule

/* hdl/sci_ctrl.sv */
// Stepper sequencer: calibration, segment runs, phase stepping and status.
// Depends on sci_pkg, sci_avg and the assertion macro header.
`include "stepper_calibrate_and_index_macros.svh"
module sci_ctrl import sci_pkg::*; #(
	parameter int PARTS       = PARTS_DEF,
	parameter int CAL_ROUNDS  = CAL_ROUNDS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  req_item_t           item,
	input  logic [OFFSET_W-1:0] opening_offset,
	output rsp_item_t           res
);
	localparam int CW = COUNT_WIDTH;
	localparam int PW = (PARTS > 1) ? $clog2(PARTS) : 1;
	localparam int RW = $clog2(CAL_ROUNDS + 1);
	localparam int TW = ((CW > OFFSET_W) ? CW : OFFSET_W) + 1;
	localparam logic [CW-1:0] COUNT_MAX  = {CW{1'b1}};
	localparam logic [PW-1:0] LAST_PART  = PW'(PARTS - 1);
	localparam logic [RW-1:0] ROUNDS     = RW'(CAL_ROUNDS);
	localparam logic [PARTS_LEFT_W-1:0] ALL_PARTS = PARTS_LEFT_W'(PARTS);

	mode_t                   mode_q, mode_d;
	logic [2:0]              phase_q, phase_d;
	logic [3:0]              coil_q, coil_d;
	logic [CW-1:0]           step_cnt_q, step_cnt_d;
	logic [RW-1:0]           round_cnt_q, round_cnt_d;
	logic                    cal_q, cal_d;
	logic [CW-1:0]           rev_q, rev_d;
	logic [CW-1:0]           seg_base_q, seg_base_d;
	logic [PW-1:0]           seg_extra_q, seg_extra_d;
	logic [PW-1:0]           part_ptr_q, part_ptr_d;
	logic [PARTS_LEFT_W-1:0] parts_left_q, parts_left_d;
	logic [CW-1:0]           steps_left_q, steps_left_d;
	logic                    back_q, back_d;

	status_t                 status_d;
	avg_ctl_t                avg_ctl;
	logic [CW-1:0]           avg_quot;
	logic [CW-1:0]           avg_base;
	logic [PW-1:0]           avg_rem;
	logic                    do_step;
	logic                    step_back;
	logic                    do_finish;
	logic [PW-1:0]           ptr_nxt;
	logic [CW-1:0]           seg_cur;
	logic [CW-1:0]           seg_nxt;
	logic [TW-1:0]           final_sum;
	logic [CW-1:0]           final_len;
	logic [PARTS_LEFT_W-1:0] parts_dec;

	sci_avg #(
		.PARTS       (PARTS),
		.CAL_ROUNDS  (CAL_ROUNDS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_avg (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (avg_ctl),
		.quot     (avg_quot),
		.seg_base (avg_base),
		.seg_rem  (avg_rem)
	);

	// Segment pointer after the current segment, in the move direction
	always_comb begin
		if (back_q) begin
			ptr_nxt = (part_ptr_q == '0) ? LAST_PART : part_ptr_q - 1'b1;
		end else begin
			ptr_nxt = (part_ptr_q == LAST_PART) ? '0 : part_ptr_q + 1'b1;
		end
	end

	// Segment lengths: the last segment also carries the remainder
	assign seg_cur = seg_base_q + ((part_ptr_q == LAST_PART) ? CW'(seg_extra_q) : '0);
	assign seg_nxt = seg_base_q + ((ptr_nxt == LAST_PART) ? CW'(seg_extra_q) : '0);

	// Final move length: average plus offset, saturated
	assign final_sum = TW'(avg_quot) + TW'(opening_offset);
	assign final_len = (final_sum > TW'(COUNT_MAX)) ? COUNT_MAX : final_sum[CW-1:0];

	assign parts_dec = (parts_left_q != '0) ? parts_left_q - 1'b1 : parts_left_q;

	// Next state for one item
	always_comb begin
		mode_d       = mode_q;
		phase_d      = phase_q;
		coil_d       = coil_q;
		step_cnt_d   = step_cnt_q;
		round_cnt_d  = round_cnt_q;
		cal_d        = cal_q;
		rev_d        = rev_q;
		seg_base_d   = seg_base_q;
		seg_extra_d  = seg_extra_q;
		part_ptr_d   = part_ptr_q;
		parts_left_d = parts_left_q;
		steps_left_d = steps_left_q;
		back_d       = back_q;
		status_d     = ST_NONE;
		avg_ctl      = '0;
		do_step      = 1'b0;
		step_back    = 1'b0;
		do_finish    = 1'b0;

		if (fire) begin
			if (mode_q == M_IDLE) begin
				case (item.cmd)
					CMD_CAL: begin
						step_cnt_d    = '0;
						round_cnt_d   = '0;
						avg_ctl.clear = 1'b1;
						mode_d        = M_SEEK1;
						status_d      = ST_ACCEPT;
					end
					CMD_STATUS: begin
						status_d = cal_q ? ST_ACCEPT : ST_NOCAL;
					end
					CMD_RUN: begin
						if (!cal_q) begin
							status_d = ST_NOCAL;
						end else begin
							if (item.run_parts == '0) begin
								parts_left_d = ALL_PARTS;
								back_d       = 1'b0;
							end else if (item.run_parts[7]) begin
								parts_left_d = PARTS_LEFT_W'(-item.run_parts);
								back_d       = 1'b1;
							end else begin
								parts_left_d = PARTS_LEFT_W'(item.run_parts);
								back_d       = 1'b0;
							end
							steps_left_d = seg_cur;
							mode_d       = M_RUN;
							status_d     = ST_ACCEPT;
						end
					end
					default: begin
					end
				endcase
			end else begin
				if (item.cmd != CMD_TICK) begin
					status_d = ST_BUSY;
				end
				case (mode_q)
					M_SEEK1: begin
						if (item.sensor_level) do_step = 1'b1;
						else mode_d = M_BACK;
					end
					M_BACK: begin
						if (!item.sensor_level) begin
							do_step   = 1'b1;
							step_back = 1'b1;
						end else begin
							mode_d = M_SEEK2;
						end
					end
					M_SEEK2: begin
						if (item.sensor_level) do_step = 1'b1;
						else mode_d = M_LOW;
					end
					M_LOW: begin
						if (!item.sensor_level) begin
							do_step = 1'b1;
							if (step_cnt_q != COUNT_MAX) begin
								step_cnt_d  = step_cnt_q + 1'b1;
								avg_ctl.inc = 1'b1;
							end
						end else begin
							mode_d = M_HIGH;
						end
					end
					M_HIGH: begin
						if (item.sensor_level) begin
							do_step = 1'b1;
							if (step_cnt_q != COUNT_MAX) begin
								step_cnt_d  = step_cnt_q + 1'b1;
								avg_ctl.inc = 1'b1;
							end
						end else begin
							step_cnt_d  = '0;
							round_cnt_d = round_cnt_q + 1'b1;
							if (round_cnt_q + 1'b1 >= ROUNDS) begin
								steps_left_d = final_len;
								mode_d       = M_FINAL;
								if (final_len == '0) do_finish = 1'b1;
							end else begin
								mode_d = M_LOW;
							end
						end
					end
					M_FINAL: begin
						if (steps_left_q != '0) begin
							do_step      = 1'b1;
							steps_left_d = steps_left_q - 1'b1;
							if (steps_left_q == CW'(1)) do_finish = 1'b1;
						end else begin
							do_finish = 1'b1;
						end
					end
					M_RUN: begin
						if (steps_left_q != '0) begin
							do_step      = 1'b1;
							step_back    = back_q;
							steps_left_d = steps_left_q - 1'b1;
						end else begin
							part_ptr_d   = ptr_nxt;
							parts_left_d = parts_dec;
							if (parts_dec == '0) mode_d = M_IDLE;
							else steps_left_d = seg_nxt;
						end
					end
					default: begin
						mode_d = M_IDLE;
					end
				endcase
			end

			// Drive the coils from the current phase, then advance it
			if (do_step) begin
				coil_d  = phase_pattern(phase_q);
				phase_d = step_back ? phase_q - 3'd1 : phase_q + 3'd1;
			end

			// Latch the calibration results
			if (do_finish) begin
				rev_d       = avg_quot;
				seg_base_d  = avg_base;
				seg_extra_d = avg_rem;
				cal_d       = 1'b1;
				mode_d      = M_IDLE;
			end
		end
	end

	// Hold the controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			phase_q      <= '0;
			coil_q       <= '0;
			step_cnt_q   <= '0;
			round_cnt_q  <= '0;
			cal_q        <= 1'b0;
			rev_q        <= '0;
			seg_base_q   <= '0;
			seg_extra_q  <= '0;
			part_ptr_q   <= '0;
			parts_left_q <= '0;
			steps_left_q <= '0;
			back_q       <= 1'b0;
		end else begin
			mode_q       <= mode_d;
			phase_q      <= phase_d;
			coil_q       <= coil_d;
			step_cnt_q   <= step_cnt_d;
			round_cnt_q  <= round_cnt_d;
			cal_q        <= cal_d;
			rev_q        <= rev_d;
			seg_base_q   <= seg_base_d;
			seg_extra_q  <= seg_extra_d;
			part_ptr_q   <= part_ptr_d;
			parts_left_q <= parts_left_d;
			steps_left_q <= steps_left_d;
			back_q       <= back_d;
		end
	end

	// Result of this item
	always_comb begin
		res                  = '0;
		res.coil_pattern     = coil_d;
		res.busy_res         = (mode_d != M_IDLE);
		res.calibrated       = cal_d;
		res.revolution_steps = REV_OUT_W'(rev_d);
		res.status_code      = status_d;
	end

	// Phase and segment pointer hold between items
	`SCI_ASSERT_NEXT(a_phase_idle, !fire, $stable(phase_q) && $stable(part_ptr_q),
		"phase or segment pointer moved without an item")
	// Calibration, once done, stays done
	`SCI_ASSERT_NEXT(a_cal_sticky, cal_q, cal_q, "calibrated flag dropped")
	// Phase moves by at most one half-step per item
	`SCI_ASSERT_NEXT(a_phase_step, fire,
		(phase_q == $past(phase_q)) || (phase_q == $past(phase_q) + 3'd1) ||
		(phase_q == $past(phase_q) - 3'd1), "phase jumped by more than one step")
	// A run never leaves idle without a calibration
	`SCI_ASSERT(a_run_cal, (mode_q != M_RUN) || cal_q, "run active while not calibrated")

endmodule

/* hdl/stepper_calibrate_and_index.sv */
// Channel | Handshake           | Payload
// req     | req_valid/req_stall | req_item: cmd, run_parts, sensor_level
// rsp     | rsp_valid/rsp_stall | rsp_item: coil, busy, calibrated, rev steps, status
// cfg     | cfg_valid/cfg_ready | cfg_data: opening_offset (10 bits)
// One item per cycle while rsp_stall is low; an item passes the input register, then the result register.
// The input register feeds one pass of sequencer logic into the result register.
// rsp_stall holds the result register and, through it, the input register.
// arst_n clears all control state; opening_offset resets to 155. cfg_ready is always high.
// Top level of the half-step stepper controller.
// Depends on sci_pkg, sci_ctrl and sci_avg.
module stepper_calibrate_and_index import sci_pkg::*; #(
	parameter int PARTS       = PARTS_DEF,
	parameter int CAL_ROUNDS  = CAL_ROUNDS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  req_item_t           req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_item_t           rsp_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [OFFSET_W-1:0] cfg_data
);
	logic                valid_s1;
	req_item_t           item_s1;
	logic                rsp_valid_s2;
	rsp_item_t           rsp_item_s2;
	logic [OFFSET_W-1:0] offset_q;
	logic                advance;
	logic                fire;
	rsp_item_t           res;

	assign advance   = !rsp_valid_s2 || !rsp_stall;
	assign fire      = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Write the offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	// Input register: take an item when empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req_item;
		end
	end

	sci_ctrl #(
		.PARTS       (PARTS),
		.CAL_ROUNDS  (CAL_ROUNDS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.item           (item_s1),
		.opening_offset (offset_q),
		.res            (res)
	);

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_item_s2 <= res;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp_item  = rsp_item_s2;

endmodule
